// ===== design/dipole_pair_energy_defines.svh =====
// Assertion macros used by the checker file of the dipole pair energy block
`ifndef DIPOLE_PAIR_ENERGY_DEFINES_SVH
`define DIPOLE_PAIR_ENERGY_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define DPE_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dipole pair energy check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define DPE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dipole pair energy check failed");

`endif

// ===== design/dpe_pkg.sv =====
// Types and constants of the dipole pair energy block
package dpe_pkg;

  localparam int unsigned PosW       = 16;
  localparam int unsigned MomW       = 16;
  localparam int unsigned EnergyW    = 32;
  localparam int unsigned DiffW      = 17;
  localparam int unsigned SqW        = 34;
  localparam int unsigned D2W        = 33;
  localparam int unsigned MmW        = 32;
  localparam int unsigned PProdW     = 33;
  localparam int unsigned PSumW      = 34;
  localparam int unsigned DotW       = 33;
  localparam int unsigned PMagW      = 32;
  localparam int unsigned RootW      = 32;
  localparam int unsigned SqrtRadW   = 64;
  localparam int unsigned RemW       = 34;
  localparam int unsigned DivNumW    = 61;
  localparam int unsigned DivQuoW    = 46;
  localparam int unsigned DivDenW    = 32;
  localparam int unsigned RadShift   = 30;
  localparam int unsigned CFracShift = 29;
  localparam int unsigned ProdW      = 64;
  localparam int unsigned TShift     = 28;
  localparam int unsigned TW         = ProdW - TShift;
  localparam int unsigned T3W        = TW + 2;
  localparam int unsigned TermScale  = 3;
  localparam int unsigned NW         = 40;
  localparam int unsigned VShift     = 8;
  localparam int unsigned VW         = NW - VShift;
  localparam int unsigned VFracShift = 23;
  localparam int unsigned SatBit     = 35;
  localparam int unsigned OutShift   = 4;

  localparam logic signed [EnergyW-1:0] EnergyMax = {1'b0, {(EnergyW-1){1'b1}}};
  localparam logic signed [EnergyW-1:0] EnergyMin = {1'b1, {(EnergyW-1){1'b0}}};

  typedef struct packed {
    logic        [PosW-1:0] first_pos_x;
    logic        [PosW-1:0] first_pos_y;
    logic signed [MomW-1:0] first_mom_x;
    logic signed [MomW-1:0] first_mom_y;
    logic        [PosW-1:0] second_pos_x;
    logic        [PosW-1:0] second_pos_y;
    logic signed [MomW-1:0] second_mom_x;
    logic signed [MomW-1:0] second_mom_y;
  } dpe_in_t;

  typedef struct packed {
    logic signed [EnergyW-1:0] pair_energy;
    logic                      coincident;
    logic                      saturated;
  } dpe_out_t;

  typedef struct packed {
    logic                   coinc;
    logic                   sat;
    logic                   neg;
    logic                   neg_a;
    logic                   neg_b;
    logic signed [DotW-1:0] dot;
    logic [PMagW-1:0]       mag_a;
    logic [PMagW-1:0]       mag_b;
  } dpe_side_t;

endpackage

// ===== design/dpe_sqrt.sv =====
// Pipelined integer square root, one root bit per stage
module dpe_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [dpe_pkg::SqrtRadW-1:0]  rad_i,
  input  dpe_pkg::dpe_side_t            side_i,
  output logic                          valid_o,
  output logic [dpe_pkg::RootW-1:0]     root_o,
  output dpe_pkg::dpe_side_t            side_o
);
  import dpe_pkg::*;

  logic [RootW-1:0]    valid_q;
  logic [SqrtRadW-1:0] rad_q  [RootW-1];
  logic [RemW-1:0]     rem_q  [RootW-1];
  logic [RootW-1:0]    root_q [RootW];
  dpe_side_t           side_q [RootW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[RootW-2:0], valid_i};
    end
  end

  for (genvar j = 0; j < RootW; j++) begin : g_stage
    logic [SqrtRadW-1:0] rad_in;
    logic [RemW-1:0]     rem_in;
    logic [RootW-1:0]    root_in;
    dpe_side_t           side_in;
    logic [RemW+1:0]     tval;
    logic [RemW+2:0]     diff;

    if (j == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rad_in  = rad_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign side_in = side_q[j-1];
    end

    assign tval = {rem_in, rad_in[SqrtRadW-1-2*j -: 2]};
    assign diff = {1'b0, tval} - {3'b000, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[j] <= {root_in[RootW-2:0], !diff[RemW+2]};
        side_q[j] <= side_in;
      end
    end

    if (j < RootW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= diff[RemW+2] ? tval[RemW-1:0] : diff[RemW-1:0];
          rad_q[j] <= rad_in;
        end
      end
    end
  end

  assign valid_o = valid_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign side_o  = side_q[RootW-1];

endmodule

// ===== design/dpe_div.sv =====
// Pipelined restoring divider, one quotient bit per stage
module dpe_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [dpe_pkg::DivNumW-1:0]  num_i,
  input  logic [dpe_pkg::DivDenW-1:0]  den_i,
  input  dpe_pkg::dpe_side_t           side_i,
  output logic                         valid_o,
  output logic [dpe_pkg::DivQuoW-1:0]  quo_o,
  output logic [dpe_pkg::DivDenW-1:0]  den_o,
  output dpe_pkg::dpe_side_t           side_o
);
  import dpe_pkg::*;

  logic [DivQuoW-1:0] valid_q;
  logic [DivDenW-1:0] rem_q  [DivQuoW-1];
  logic [DivQuoW-1:0] num_q  [DivQuoW-1];
  logic [DivQuoW-1:0] quo_q  [DivQuoW];
  logic [DivDenW-1:0] den_q  [DivQuoW];
  dpe_side_t          side_q [DivQuoW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[DivQuoW-2:0], valid_i};
    end
  end

  for (genvar j = 0; j < DivQuoW; j++) begin : g_stage
    logic [DivDenW-1:0] rem_in;
    logic [DivQuoW-1:0] num_in;
    logic [DivQuoW-1:0] quo_in;
    logic [DivDenW-1:0] den_in;
    dpe_side_t          side_in;
    logic [DivDenW:0]   trial;
    logic [DivDenW:0]   diff;

    if (j == 0) begin : g_first
      assign rem_in  = DivDenW'(num_i[DivNumW-1:DivQuoW]);
      assign num_in  = num_i[DivQuoW-1:0];
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign num_in  = num_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign den_in  = den_q[j-1];
      assign side_in = side_q[j-1];
    end

    assign trial = {rem_in, num_in[DivQuoW-1-j]};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[j]  <= {quo_in[DivQuoW-2:0], !diff[DivDenW]};
        den_q[j]  <= den_in;
        side_q[j] <= side_in;
      end
    end

    if (j < DivQuoW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= diff[DivDenW] ? trial[DivDenW-1:0] : diff[DivDenW-1:0];
          num_q[j] <= num_in;
        end
      end
    end
  end

  assign valid_o = valid_q[DivQuoW-1];
  assign quo_o   = quo_q[DivQuoW-1];
  assign den_o   = den_q[DivQuoW-1];
  assign side_o  = side_q[DivQuoW-1];

endmodule

// ===== design/dipole_pair_energy.sv =====
// Dipole pair energy: top level of the streaming interaction-energy pipeline
//
// Input channel in_valid_i / in_ready_o carries one dipole pair (positions in
// unsigned Q8.8, moments in signed Q1.14) per transfer. Output channel
// out_valid_o / out_ready_i carries one result per pair: the energy in signed
// Q16.16 with its coincident and saturated flags, in input order.
// From input transfer to output valid, a pair passes registers of
// differences, products and sums, a 32-stage square root, two 46-stage
// dividers for the projected moments, registers forming the numerator,
// three more 46-stage dividers by r and the output register. Every stage
// holds one pair, so a new pair is taken every cycle while the output is
// free or being taken. When the receiver stalls, the whole pipeline holds
// and in_ready_o drops; nothing is lost or repeated. Reset clears the valid
// bits only; the block is ready in the first cycle after reset.
module dipole_pair_energy (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dpe_pkg::dpe_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dpe_pkg::dpe_out_t out_data_o
);
  import dpe_pkg::*;

  function automatic logic quo_over(input logic [DivQuoW-1:0] quo);
    return quo[DivQuoW-1:SatBit] != '0;
  endfunction

  function automatic logic [DivNumW-1:0] next_num(input logic [DivQuoW-1:0] quo,
                                                  input logic            sat);
    return sat ? '0 : {{(DivNumW-SatBit-VFracShift){1'b0}}, quo[SatBit-1:0],
                       {VFracShift{1'b0}}};
  endfunction

  logic en;

  logic                    a_valid_q;
  logic signed [DiffW-1:0] a_dx_q, a_dy_q;
  logic signed [MomW-1:0]  a_m1x_q, a_m1y_q, a_m2x_q, a_m2y_q;

  logic                     b_valid_q;
  logic signed [SqW-1:0]    b_dxx_q, b_dyy_q;
  logic signed [MmW-1:0]    b_mmx_q, b_mmy_q;
  logic signed [PProdW-1:0] b_p1x_q, b_p1y_q, b_p2x_q, b_p2y_q;

  logic                    c_valid_q;
  logic [D2W-1:0]          c_d2_q;
  logic signed [DotW-1:0]  c_dot_q;
  logic signed [PSumW-1:0] c_p1_q, c_p2_q;
  logic signed [SqW-1:0]   c_d2_d;
  logic signed [PSumW-1:0] p1_abs, p2_abs;

  logic [SqrtRadW-1:0] sq_rad;
  dpe_side_t           sq_side;
  logic                sq_valid;
  logic [RootW-1:0]    sq_root;
  dpe_side_t           sq_side_o;

  dpe_side_t          d1_side_i, d1_side_o, d2_side_o;
  logic               d1_valid, d2_valid;
  logic [DivQuoW-1:0] d1_quo, d2_quo;
  logic [DivDenW-1:0] d1_den, d2_den;

  logic               e_valid_q;
  logic [ProdW-1:0]   e_prod_q;
  logic [DivDenW-1:0] e_den_q;
  dpe_side_t          e_side_q;

  logic               f_valid_q;
  logic [T3W-1:0]     f_t3_q;
  logic [DivDenW-1:0] f_den_q;
  dpe_side_t          f_side_q;
  logic [TW-1:0]      f_t;

  logic                 g_valid_q;
  logic signed [NW-1:0] g_n_q;
  logic [DivDenW-1:0]   g_den_q;
  dpe_side_t            g_side_q;
  logic signed [NW-1:0] dot_ext, t3_ext;

  logic               h_valid_q;
  logic [VW-1:0]      h_v_q;
  logic [DivDenW-1:0] h_den_q;
  dpe_side_t          h_side_q;
  dpe_side_t          h_side_d;
  logic [NW-1:0]      n_mag;

  logic               v1_valid, v2_valid, v3_valid;
  logic [DivQuoW-1:0] v1_quo, v2_quo, v3_quo;
  logic [DivDenW-1:0] v1_den, v2_den, v3_den;
  dpe_side_t          v1_side_o, v2_side_o, v3_side_o;
  dpe_side_t          v2_side_i, v3_side_i;

  logic                      fin_sat;
  logic signed [EnergyW-1:0] fin_mag;
  dpe_out_t                  out_data_d;
  logic                      out_valid_q;
  dpe_out_t                  out_data_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      e_valid_q   <= 1'b0;
      f_valid_q   <= 1'b0;
      g_valid_q   <= 1'b0;
      h_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q   <= in_valid_i;
      b_valid_q   <= a_valid_q;
      c_valid_q   <= b_valid_q;
      e_valid_q   <= d2_valid;
      f_valid_q   <= e_valid_q;
      g_valid_q   <= f_valid_q;
      h_valid_q   <= g_valid_q;
      out_valid_q <= v3_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_dx_q  <= signed'({1'b0, in_data_i.first_pos_x}) - signed'({1'b0, in_data_i.second_pos_x});
      a_dy_q  <= signed'({1'b0, in_data_i.first_pos_y}) - signed'({1'b0, in_data_i.second_pos_y});
      a_m1x_q <= in_data_i.first_mom_x;
      a_m1y_q <= in_data_i.first_mom_y;
      a_m2x_q <= in_data_i.second_mom_x;
      a_m2y_q <= in_data_i.second_mom_y;

      b_dxx_q <= a_dx_q * a_dx_q;
      b_dyy_q <= a_dy_q * a_dy_q;
      b_mmx_q <= a_m1x_q * a_m2x_q;
      b_mmy_q <= a_m1y_q * a_m2y_q;
      b_p1x_q <= a_m1x_q * a_dx_q;
      b_p1y_q <= a_m1y_q * a_dy_q;
      b_p2x_q <= a_m2x_q * a_dx_q;
      b_p2y_q <= a_m2y_q * a_dy_q;

      c_d2_q  <= c_d2_d[D2W-1:0];
      c_dot_q <= DotW'(b_mmx_q) + DotW'(b_mmy_q);
      c_p1_q  <= PSumW'(b_p1x_q) + PSumW'(b_p1y_q);
      c_p2_q  <= PSumW'(b_p2x_q) + PSumW'(b_p2y_q);
    end
  end

  assign c_d2_d = b_dxx_q + b_dyy_q;

  // separation squared, shifted for r in Q.23
  assign sq_rad = {1'b0, c_d2_q, {RadShift{1'b0}}};
  assign p1_abs = c_p1_q[PSumW-1] ? -c_p1_q : c_p1_q;
  assign p2_abs = c_p2_q[PSumW-1] ? -c_p2_q : c_p2_q;

  always_comb begin
    sq_side       = '0;
    sq_side.coinc = (c_d2_q == '0);
    sq_side.neg_a = c_p1_q[PSumW-1];
    sq_side.neg_b = c_p2_q[PSumW-1];
    sq_side.dot   = c_dot_q;
    sq_side.mag_a = p1_abs[PMagW-1:0];
    sq_side.mag_b = p2_abs[PMagW-1:0];
  end

  dpe_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_valid_q),
    .rad_i   (sq_rad),
    .side_i  (sq_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side_o)
  );

  dpe_div u_div_c1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .num_i   ({sq_side_o.mag_a, {CFracShift{1'b0}}}),
    .den_i   (sq_root),
    .side_i  (sq_side_o),
    .valid_o (d1_valid),
    .quo_o   (d1_quo),
    .den_o   (d1_den),
    .side_o  (d1_side_o)
  );

  always_comb begin
    d1_side_i       = d1_side_o;
    d1_side_i.mag_a = d1_quo[PMagW-1:0];
  end

  dpe_div u_div_c2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d1_valid),
    .num_i   ({d1_side_o.mag_b, {CFracShift{1'b0}}}),
    .den_i   (d1_den),
    .side_i  (d1_side_i),
    .valid_o (d2_valid),
    .quo_o   (d2_quo),
    .den_o   (d2_den),
    .side_o  (d2_side_o)
  );

  assign f_t     = e_prod_q[ProdW-1:TShift];
  assign dot_ext = NW'(f_side_q.dot);
  assign t3_ext  = signed'(NW'(f_t3_q));
  assign n_mag   = g_n_q[NW-1] ? NW'(-g_n_q) : NW'(g_n_q);

  always_comb begin
    h_side_d     = g_side_q;
    h_side_d.neg = g_n_q[NW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_prod_q <= ProdW'(d2_side_o.mag_a) * ProdW'(d2_quo[PMagW-1:0]);
      e_den_q  <= d2_den;
      e_side_q <= d2_side_o;

      f_t3_q   <= T3W'(f_t) * T3W'(TermScale);
      f_den_q  <= e_den_q;
      f_side_q <= e_side_q;

      g_n_q    <= (f_side_q.neg_a ^ f_side_q.neg_b) ? dot_ext + t3_ext : dot_ext - t3_ext;
      g_den_q  <= f_den_q;
      g_side_q <= f_side_q;

      h_v_q    <= n_mag[NW-1:VShift];
      h_den_q  <= g_den_q;
      h_side_q <= h_side_d;
    end
  end

  dpe_div u_div_v1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (h_valid_q),
    .num_i   ({{(DivNumW-VW-VFracShift){1'b0}}, h_v_q, {VFracShift{1'b0}}}),
    .den_i   (h_den_q),
    .side_i  (h_side_q),
    .valid_o (v1_valid),
    .quo_o   (v1_quo),
    .den_o   (v1_den),
    .side_o  (v1_side_o)
  );

  always_comb begin
    v2_side_i     = v1_side_o;
    v2_side_i.sat = v1_side_o.sat || quo_over(v1_quo);
  end

  dpe_div u_div_v2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1_valid),
    .num_i   (next_num(v1_quo, v2_side_i.sat)),
    .den_i   (v1_den),
    .side_i  (v2_side_i),
    .valid_o (v2_valid),
    .quo_o   (v2_quo),
    .den_o   (v2_den),
    .side_o  (v2_side_o)
  );

  always_comb begin
    v3_side_i     = v2_side_o;
    v3_side_i.sat = v2_side_o.sat || quo_over(v2_quo);
  end

  dpe_div u_div_v3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_valid),
    .num_i   (next_num(v2_quo, v3_side_i.sat)),
    .den_i   (v2_den),
    .side_i  (v3_side_i),
    .valid_o (v3_valid),
    .quo_o   (v3_quo),
    .den_o   (v3_den),
    .side_o  (v3_side_o)
  );

  assign fin_sat = v3_side_o.sat || quo_over(v3_quo) || (v3_den == '0);
  assign fin_mag = EnergyW'(v3_quo[SatBit-1:OutShift]);

  always_comb begin
    out_data_d = '0;
    if (v3_side_o.coinc) begin
      out_data_d.coincident = 1'b1;
    end else if (fin_sat) begin
      out_data_d.saturated   = 1'b1;
      out_data_d.pair_energy = v3_side_o.neg ? EnergyMin : EnergyMax;
    end else begin
      out_data_d.pair_energy = v3_side_o.neg ? -fin_mag : fin_mag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== design/dpe_checker.sv =====
// Port-level checks of the dipole pair energy block and their bind
`include "dipole_pair_energy_defines.svh"

module dpe_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input dpe_pkg::dpe_out_t out_data_o
);
  import dpe_pkg::*;

  `DPE_ASSERT_IMPL(a_ready_when_empty, !out_valid_o, in_ready_o)
  `DPE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `DPE_ASSERT_IMPL(a_coinc_zero, out_valid_o && out_data_o.coincident, out_data_o.pair_energy == '0 && !out_data_o.saturated)
  `DPE_ASSERT_IMPL(a_sat_limit, out_valid_o && out_data_o.saturated, out_data_o.pair_energy == EnergyMax || out_data_o.pair_energy == EnergyMin)

endmodule

bind dipole_pair_energy dpe_checker u_dpe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== sim/dipole_pair_energy_test.sv =====
// Self-checking testbench of the dipole pair energy block with directed pairs and a random stream of dipole pairs
module dipole_pair_energy_test;
  import dpe_pkg::*;

  localparam int unsigned Latency  = 270;
  localparam int unsigned MaxCycle = 1000000;
  localparam int unsigned NumRand  = 1550;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  dpe_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  dpe_out_t out_data_o;

  dpe_in_t  pending_pairs[$];
  dpe_out_t expected_energies[$];
  int       fails = 0;
  int       cycles = 0;
  int       send_gap;
  int       recv_stall;

  dipole_pair_energy u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit [63:0] int_sqrt(bit [63:0] n);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic bit [63:0] magnitude(longint x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  function automatic dpe_out_t pair_energy_of(dpe_in_t p);
    dpe_out_t  r;
    longint    dx, dy, dot, p1, p2, t, n;
    longint    m1x, m1y, m2x, m2y;
    bit [63:0] d2, rq, c1, c2, v;
    bit        neg;
    r = '0;
    m1x = longint'(p.first_mom_x);
    m1y = longint'(p.first_mom_y);
    m2x = longint'(p.second_mom_x);
    m2y = longint'(p.second_mom_y);
    dx = longint'({1'b0, p.first_pos_x}) - longint'({1'b0, p.second_pos_x});
    dy = longint'({1'b0, p.first_pos_y}) - longint'({1'b0, p.second_pos_y});
    d2 = 64'(dx * dx) + 64'(dy * dy);
    if (d2 == 0) begin
      r.coincident = 1'b1;
      return r;
    end
    rq = int_sqrt(d2 << 30);
    dot = m1x * m2x + m1y * m2y;
    p1 = m1x * dx + m1y * dy;
    p2 = m2x * dx + m2y * dy;
    c1 = (magnitude(p1) << 29) / rq;
    c2 = (magnitude(p2) << 29) / rq;
    t = longint'((c1 * c2) >> 28);
    if ((p1 < 0) != (p2 < 0)) t = -t;
    n = dot - 3 * t;
    neg = n < 0;
    v = magnitude(n) >> 8;
    for (int k = 0; k < 3 && !r.saturated; k++) begin
      v = (v << 23) / rq;
      if (v >= (64'd1 << 35)) r.saturated = 1'b1;
    end
    if (r.saturated) r.pair_energy = neg ? EnergyMin : EnergyMax;
    else r.pair_energy = neg ? -32'(v >> 4) : 32'(v >> 4);
    return r;
  endfunction

  function automatic int idle_length();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 65) return 0;
    if (sel < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [15:0] rand_moment();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic [15:0] near_position(logic [15:0] base);
    case ($urandom_range(0, 3))
      0: return base;
      1: return base + 16'(int'($urandom_range(0, 8)) - 4);
      2: return base + 16'(int'($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_pair(logic [15:0] x1, logic [15:0] y1, logic [15:0] mx1,
                          logic [15:0] my1, logic [15:0] x2, logic [15:0] y2,
                          logic [15:0] mx2, logic [15:0] my2);
    dpe_in_t item;
    item = '{x1, y1, mx1, my1, x2, y2, mx2, my2};
    pending_pairs.insert(pending_pairs.size(), item);
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    fails++;
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    dpe_in_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap   <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) send_gap <= idle_length();
      if (send_gap > 0 && !in_valid_i) begin
        send_gap   <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_pairs.size() > 0 && !(in_valid_i && idle_length() > 3)) begin
        nxt = pending_pairs.pop_front();
        in_data_i  <= nxt;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    dpe_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall  <= 0;
    end else begin
      if (in_valid_i && in_ready_o)
        expected_energies.insert(expected_energies.size(), pair_energy_of(in_data_i));
      if (out_valid_o && out_ready_i) begin
        if (expected_energies.size() == 0) begin
          report("unexpected result", out_data_o.pair_energy, 0);
        end else begin
          want = expected_energies.pop_front();
          if (out_data_o.pair_energy !== want.pair_energy)
            report("pair_energy", out_data_o.pair_energy, want.pair_energy);
          if (out_data_o.coincident !== want.coincident)
            report("coincident", out_data_o.coincident, want.coincident);
          if (out_data_o.saturated !== want.saturated)
            report("saturated", out_data_o.saturated, want.saturated);
        end
      end
      if (recv_stall > 0) begin
        recv_stall  <= recv_stall - 1;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        recv_stall  <= idle_length();
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycle) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [15:0] x1, y1;
    rst_ni = 1'b0;

    add_pair(16'h1234, 16'h5678, 16'h4000, 16'h0000, 16'h1234, 16'h5678, 16'h4000, 16'h0000);
    add_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0000);
    add_pair(16'h0100, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000);
    add_pair(16'h0000, 16'h0100, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000);
    add_pair(16'h0100, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'hC000);
    add_pair(16'hFFFF, 16'hFFFF, 16'h4000, 16'h4000, 16'h0000, 16'h0000, 16'hC000, 16'hC000);
    add_pair(16'h0000, 16'h0000, 16'hC000, 16'h4000, 16'hFFFF, 16'hFFFF, 16'h4000, 16'hC000);
    add_pair(16'h0001, 16'h0000, 16'h4000, 16'h4000, 16'h0000, 16'h0000, 16'h4000, 16'h4000);
    add_pair(16'h0000, 16'h0001, 16'hC000, 16'h4000, 16'h0000, 16'h0000, 16'h4000, 16'hC000);
    add_pair(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8001, 16'h7FFF, 16'h8000, 16'h7FFF);
    add_pair(16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000);
    add_pair(16'h0300, 16'h0400, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000);
    add_pair(16'h0100, 16'h0100, 16'h2D41, 16'h2D41, 16'h0000, 16'h0000, 16'h2D41, 16'h2D41);
    add_pair(16'h0010, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000);
    add_pair(16'h0010, 16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000);
    add_pair(16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF);
    add_pair(16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 16'h0000, 16'h0002, 16'hFFFF, 16'h0001);

    for (int i = 0; i < NumRand; i++) begin
      x1 = 16'($urandom);
      y1 = 16'($urandom);
      add_pair(x1, y1, rand_moment(), rand_moment(), near_position(x1), near_position(y1),
               rand_moment(), rand_moment());
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (pending_pairs.size() > 0 || in_valid_i || expected_energies.size() > 0)
      @(posedge clk_i);
    repeat (Latency + 30) @(posedge clk_i);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+design
design/dpe_pkg.sv
design/dpe_sqrt.sv
design/dpe_div.sv
design/dipole_pair_energy.sv
design/dpe_checker.sv
sim/dipole_pair_energy_test.sv
